// ----- hw/rtl/stimg_pkg.sv -----
`default_nettype none
package stimg_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W       = 32;
	localparam int GAP_W       = 31;
	localparam int SLOT_W      = 7;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_CLEAR  = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_MIN_KEY_GAP = 1'b0;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_TOO_CLOSE = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_DECIDE
	} state_t;

	typedef struct packed {
		logic                    action;
		logic signed [KEY_W-1:0] new_key;
		logic signed [KEY_W-1:0] new_value;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [SLOT_W-1:0]   slot;
		logic [SLOT_W-1:0]   entry_count;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} dp_cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/stimg_ctrl.sv -----
`default_nettype none
module stimg_ctrl import stimg_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output dp_cmd_t   cmd
);

	state_t state_q, state_d;
	logic   rsp_valid_q, rsp_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		req_ready   = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				// hold until the result register is free
				if (!rsp_valid_q || rsp_ready) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		if (cmd.commit) begin
			rsp_valid_d = 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_d = 1'b0;
		end else begin
			rsp_valid_d = rsp_valid_q;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule
`default_nettype wire

// ----- hw/rtl/stimg_datapath.sv -----
`default_nettype none
module stimg_datapath import stimg_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire dp_cmd_t          cmd,
	input  wire req_t             req,
	input  wire logic [GAP_W-1:0] min_key_gap,
	output rsp_t                  rsp
);

	logic signed [KEY_W-1:0] key_q   [TABLE_DEPTH];
	logic signed [KEY_W-1:0] value_q [TABLE_DEPTH];
	logic [CNT_W-1:0]        count_q;

	req_t                    req_s1;
	logic [TABLE_DEPTH-1:0]  le_s1, close_s1;
	logic [TABLE_DEPTH-1:0]  le_d, close_d;
	rsp_t                    rsp_q;

	logic [KEY_W:0]          gap_ext;
	logic [TABLE_DEPTH-1:0]  valid, lev;
	logic [TABLE_DEPTH:0]    is_slot;
	logic [CNT_W-1:0]        slot_bin;
	logic                    close_any, full, is_clear, insert_ok;

	// per-cell compare against the incoming key
	always_comb begin
		logic [KEY_W:0] k_ext, n_ext, d_dn, d_up;
		gap_ext = {2'b00, min_key_gap};
		n_ext   = {req.new_key[KEY_W-1], req.new_key};
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			k_ext      = {key_q[i][KEY_W-1], key_q[i]};
			d_dn       = n_ext - k_ext;
			d_up       = k_ext - n_ext;
			le_d[i]    = key_q[i] <= req.new_key;
			close_d[i] = le_d[i] ? (d_dn <= gap_ext) : (d_up <= gap_ext);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_s1   <= req;
			le_s1    <= le_d;
			close_s1 <= close_d;
		end
	end

	// reduce the cell flags; lev is a prefix of ones over the sorted cells
	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			valid[i] = CNT_W'(i) < count_q;
		end
		lev        = le_s1 & valid;
		is_slot[0] = !lev[0];
		for (int i = 1; i < TABLE_DEPTH; i++) begin
			is_slot[i] = lev[i-1] & !lev[i];
		end
		is_slot[TABLE_DEPTH] = lev[TABLE_DEPTH-1];
		slot_bin = '0;
		for (int i = 0; i <= TABLE_DEPTH; i++) begin
			slot_bin = slot_bin | (is_slot[i] ? CNT_W'(i) : CNT_W'(0));
		end
		close_any = |(close_s1 & valid);
		full      = count_q == CNT_W'(TABLE_DEPTH);
		is_clear  = req_s1.action == ACT_CLEAR;
		insert_ok = cmd.commit && !is_clear && !close_any && !full;
	end

	// shift cells above the slot up one place, drop the new pair in
	always_ff @(posedge clk) begin
		if (insert_ok) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (is_slot[i]) begin
					key_q[i]   <= req_s1.new_key;
					value_q[i] <= req_s1.new_value;
				end else if (i > 0 && !lev[(i > 0) ? i-1 : 0]) begin
					key_q[i]   <= key_q[(i > 0) ? i-1 : 0];
					value_q[i] <= value_q[(i > 0) ? i-1 : 0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit && is_clear) begin
			count_q <= '0;
		end else if (insert_ok) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (is_clear) begin
				rsp_q.status      <= ST_DONE;
				rsp_q.slot        <= '0;
				rsp_q.entry_count <= '0;
			end else begin
				priority if (close_any) begin
					rsp_q.status <= ST_TOO_CLOSE;
				end else if (full) begin
					rsp_q.status <= ST_FULL;
				end else begin
					rsp_q.status <= ST_DONE;
				end
				rsp_q.slot        <= SLOT_W'(slot_bin);
				rsp_q.entry_count <= SLOT_W'(insert_ok ? count_q + CNT_W'(1) : count_q);
			end
		end
	end

	assign rsp = rsp_q;

endmodule
`default_nettype wire

// ----- hw/rtl/sorted_table_insert_min_gap.sv -----
`default_nettype none
// Sorted key/value table with a minimum key gap. Every request beat either
// inserts a signed Q16.16 pair or clears the table, and yields one response
// beat with a status (done, too close, full), the sorted slot of the key and
// the entry count afterwards. At the edge that accepts the request beat all
// 64 table cells compare their key with the new key in parallel and register
// an order flag and a too-close flag; then, at the commit edge, those flags
// are reduced, the cells at and above the slot shift up one place and the
// result register loads. A request is taken only while the block is idle;
// if the previous response beat still waits, the commit edge holds until it
// is taken. Table contents need no clearing pass after reset: only cells
// below the entry count are ever consulted. min_key_gap is written over the
// APB port at byte address 0 and must only change while idle.
module sorted_table_insert_min_gap import stimg_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// request channel
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire req_t               req,
	// response channel
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output rsp_t                    rsp,
	// configuration port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready
);

	dp_cmd_t          cmd;
	logic [GAP_W-1:0] min_key_gap_q;
	logic             reg_idx;
	logic             cfg_we;

	// Register index sits above the byte offset; index one is beyond the list.
	assign reg_idx = paddr[2];
	assign cfg_we  = psel && penable && pwrite && (reg_idx == REG_MIN_KEY_GAP);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_key_gap_q <= '0;
		end else if (cfg_we) begin
			min_key_gap_q <= pwdata[GAP_W-1:0];
		end
	end

	// Read back the gap; unmapped addresses read as zero.
	assign prdata = (reg_idx == REG_MIN_KEY_GAP) ?
		{{(PDATA_W-GAP_W){1'b0}}, min_key_gap_q} : '0;

	// Sequence each beat: capture the cell compares, then commit and respond.
	stimg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	// Table cells, the compare flags and the result register.
	stimg_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.req         (req),
		.min_key_gap (min_key_gap_q),
		.rsp         (rsp)
	);

endmodule
`default_nettype wire

// ----- test/sorted_table_insert_min_gap_test.sv -----
module sorted_table_insert_min_gap_test;
	timeunit 1ns;
	timeprecision 1ps;

	import stimg_pkg::*;

	localparam int RAND_ITEMS = 1950;
	localparam int PHASES     = 8;
	localparam int PHASE_LEN  = RAND_ITEMS / PHASES;
	localparam int HOLD_LEN   = 240;

	// min_key_gap lives at register index 0, byte address 0
	localparam logic [PADDR_W-1:0] GAP_ADDR = {REG_MIN_KEY_GAP, 2'b00};

	typedef enum logic {
		ROW_BEAT,
		ROW_GAP
	} row_kind_t;

	// one line of the directed stimulus table
	typedef struct {
		row_kind_t          kind;
		req_t               beat;
		logic [GAP_W-1:0]   gap;
		bit                 typed;
		rsp_t               want;
	} plan_row_t;

	// a response beat still owed by the block, with the request that caused it
	typedef struct {
		req_t beat;
		rsp_t want;
	} awaited_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	req_t               req       = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	rsp_t               rsp;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [PADDR_W-1:0] paddr     = '0;
	logic [PDATA_W-1:0] pwdata    = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	sorted_table_insert_min_gap dut (
		.clk,
		.arst_n,
		.req_valid,
		.req_ready,
		.req,
		.rsp_valid,
		.rsp_ready,
		.rsp,
		.psel,
		.penable,
		.pwrite,
		.paddr,
		.pwdata,
		.prdata,
		.pready
	);

	always #4 clk = ~clk;

	// Shadow copy of the table: sorted keys, their values, the fill count and
	// the gap register as last written.
	logic signed [KEY_W-1:0] held_key [TABLE_DEPTH];
	logic signed [KEY_W-1:0] held_val [TABLE_DEPTH];
	int                      held_cnt = 0;
	logic [GAP_W-1:0]        gap_now  = '0;

	awaited_t  awaited [$];
	plan_row_t plan [$];

	int burst_left = 0;
	int n_bad      = 0;
	int n_beats    = 0;
	int n_placed   = 0;
	int n_close    = 0;
	int n_full     = 0;
	int n_clear    = 0;
	int n_gap_set  = 0;

	function automatic rsp_t res(status_t s, int slot, int cnt);
		rsp_t o;
		o.status      = s;
		o.slot        = SLOT_W'(slot);
		o.entry_count = SLOT_W'(cnt);
		return o;
	endfunction

	function automatic plan_row_t typed_row(logic act, logic [KEY_W-1:0] k,
			logic [KEY_W-1:0] v, rsp_t want);
		plan_row_t r;
		r.kind           = ROW_BEAT;
		r.beat.action    = act;
		r.beat.new_key   = k;
		r.beat.new_value = v;
		r.gap            = '0;
		r.typed          = 1'b1;
		r.want           = want;
		return r;
	endfunction

	function automatic plan_row_t open_row(logic act, logic [KEY_W-1:0] k,
			logic [KEY_W-1:0] v);
		plan_row_t r;
		r       = typed_row(act, k, v, '0);
		r.typed = 1'b0;
		return r;
	endfunction

	function automatic plan_row_t gap_row(logic [GAP_W-1:0] g);
		plan_row_t r;
		r      = open_row(ACT_INSERT, '0, '0);
		r.kind = ROW_GAP;
		r.gap  = g;
		return r;
	endfunction

	// append one line to the directed table
	function automatic void add_row(input plan_row_t r);
		plan.insert(plan.size(), r);
	endfunction

	// Absolute key distance, exact in 64 bits so the full signed span never wraps.
	function automatic bit too_close(logic signed [KEY_W-1:0] a, logic signed [KEY_W-1:0] b);
		longint d;
		d = longint'(a) - longint'(b);
		if (d < 0)
			d = -d;
		return d <= longint'({1'b0, gap_now});
	endfunction

	// Apply one request beat to the shadow table and return the response it owes.
	function automatic rsp_t place_pair(req_t r);
		int                      pos;
		bit                      near;
		logic signed [KEY_W-1:0] k;
		if (r.action == ACT_CLEAR) begin
			held_cnt = 0;
			return res(ST_DONE, 0, 0);
		end
		k    = $signed(r.new_key);
		pos  = held_cnt;
		near = 1'b0;
		// slot = first stored key strictly above the new one
		for (int i = 0; i < held_cnt; i++) begin
			if (held_key[i] > k) begin
				pos = i;
				break;
			end
		end
		if (pos < held_cnt && too_close(held_key[pos], k))
			near = 1'b1;
		if (pos > 0 && too_close(held_key[pos - 1], k))
			near = 1'b1;
		// the gap check wins over the full check
		if (near)
			return res(ST_TOO_CLOSE, pos, held_cnt);
		if (held_cnt >= TABLE_DEPTH)
			return res(ST_FULL, pos, held_cnt);
		for (int i = held_cnt; i > pos; i--) begin
			held_key[i] = held_key[i - 1];
			held_val[i] = held_val[i - 1];
		end
		held_key[pos] = k;
		held_val[pos] = $signed(r.new_value);
		held_cnt++;
		return res(ST_DONE, pos, held_cnt);
	endfunction

	// Random key: plain noise, a probe right at or around a stored neighbor's
	// gap boundary, an extreme, or a packed small range that crowds the table.
	function automatic logic signed [KEY_W-1:0] pick_key();
		int                      sel;
		logic signed [KEY_W-1:0] base;
		logic [KEY_W-1:0]        off;
		sel = $urandom_range(0, 99);
		if (sel < 35 || held_cnt == 0)
			return $urandom;
		if (sel < 65) begin
			base = held_key[$urandom_range(0, held_cnt - 1)];
			case ($urandom_range(0, 3))
				0: off = '0;
				1: off = {1'b0, gap_now};
				2: off = {1'b0, gap_now} + 1;
				default: off = $urandom_range(0, gap_now);
			endcase
			return $urandom_range(0, 1) ? base + off : base - off;
		end
		if (sel < 80) begin
			case ($urandom_range(0, 4))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h0000_0000;
				3: return 32'h0000_0001;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		return $urandom_range(0, 'h7FFFF) - 'h40000;
	endfunction

	task automatic report_bad(input string msg);
		n_bad++;
		if (n_bad <= 10)
			$display("%s", msg);
	endtask

	// Offer one request beat, with the sender's own burst/gap pattern in front.
	// Valid stays high on return, so a back-to-back beat just overwrites the
	// payload; callers that pause must lower valid first.
	task automatic offer(input req_t r, input bit typed, input rsp_t want);
		int       idle;
		rsp_t     pred;
		awaited_t owed;
		if (burst_left == 0) begin
			idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (idle > 0) begin
				req_valid <= 1'b0;
				repeat (idle) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		burst_left--;
		n_beats++;
		pred = place_pair(r);
		if (typed)
			pred = want;
		owed.beat = r;
		owed.want = pred;
		awaited.insert(awaited.size(), owed);
		if (r.action == ACT_CLEAR)
			n_clear++;
		else if (pred.status == ST_DONE)
			n_placed++;
		else if (pred.status == ST_TOO_CLOSE)
			n_close++;
		else
			n_full++;
	endtask

	task automatic stop_offer();
		req_valid <= 1'b0;
		burst_left = 0;
	endtask

	// Wait for every owed response; each beat yields one, so nothing runs on
	// in the block once the queue is empty.
	task automatic drain();
		while (awaited.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Write min_key_gap, then read it back in a second transfer.
	task automatic set_gap(input logic [GAP_W-1:0] g);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= GAP_ADDR;
		pwdata  <= PDATA_W'(g);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		gap_now = g;
		n_gap_set++;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[GAP_W-1:0] !== g)
			report_bad($sformatf("min_key_gap readback: expected %h, got %h", g, prdata));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_result(input rsp_t got);
		awaited_t e;
		if (awaited.size() == 0) begin
			report_bad($sformatf("response beat with nothing owed: status %0d slot %0d count %0d",
				got.status, got.slot, got.entry_count));
			return;
		end
		e = awaited.pop_front();
		if (got.status !== e.want.status || got.slot !== e.want.slot
				|| got.entry_count !== e.want.entry_count)
			report_bad($sformatf(
				"action %0d key %h: expected status %0d slot %0d count %0d, got %0d %0d %0d",
				e.beat.action, e.beat.new_key, e.want.status, e.want.slot,
				e.want.entry_count, got.status, got.slot, got.entry_count));
	endtask

	// Response side: take beats on a stall pattern that rotates through four
	// characters, and twice hold off for a long stretch so the block backs up
	// and stalls the request side.
	initial begin : rsp_side
		int cyc;
		int hold;
		int n_rx;
		cyc  = 0;
		hold = 0;
		n_rx = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				check_result(rsp);
				n_rx++;
				if (n_rx == 300 || n_rx == 1300)
					hold = HOLD_LEN;
			end
			cyc++;
			if (hold > 0) begin
				hold--;
				rsp_ready <= 1'b0;
			end else begin
				case ((cyc / 97) % 4)
					0: rsp_ready <= 1'b1;
					1: rsp_ready <= $urandom_range(0, 1);
					2: rsp_ready <= ($urandom_range(0, 3) == 0);
					default: rsp_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	initial begin : watchdog
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : req_side
		logic [GAP_W-1:0] gap_plan [PHASES];
		req_t             beat;
		int               clear_odds;

		// Directed table. Runs first on the reset gap of zero: empty table,
		// equal keys, both key extremes, then the widest gap where only a full
		// signed span or a 2^31 step gets past, then a one-unit Q16.16 gap.
		add_row(typed_row(ACT_INSERT, 32'h0000_0000, 32'h0001_0000, res(ST_DONE, 0, 1)));
		add_row(typed_row(ACT_INSERT, 32'h0000_0000, 32'hFFFF_FFFF,
			res(ST_TOO_CLOSE, 1, 1)));
		add_row(typed_row(ACT_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, res(ST_DONE, 0, 2)));
		add_row(typed_row(ACT_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, res(ST_DONE, 2, 3)));
		add_row(typed_row(ACT_INSERT, 32'h8000_0000, 32'h0000_0000,
			res(ST_TOO_CLOSE, 1, 3)));
		add_row(typed_row(ACT_INSERT, 32'h7FFF_FFFF, 32'h5555_5555,
			res(ST_TOO_CLOSE, 3, 3)));
		add_row(open_row(ACT_INSERT, 32'h0000_0001, 32'h1234_5678));
		add_row(open_row(ACT_INSERT, 32'hFFFF_FFFF, 32'hAAAA_AAAA));
		add_row(typed_row(ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, res(ST_DONE, 0, 0)));
		add_row(gap_row(31'h7FFF_FFFF));
		add_row(typed_row(ACT_INSERT, 32'h8000_0000, 32'h0000_0001, res(ST_DONE, 0, 1)));
		add_row(typed_row(ACT_INSERT, 32'h7FFF_FFFF, 32'h0000_0002, res(ST_DONE, 1, 2)));
		add_row(typed_row(ACT_INSERT, 32'h0000_0000, 32'h0000_0003,
			res(ST_TOO_CLOSE, 1, 2)));
		add_row(typed_row(ACT_CLEAR, 32'h0000_0000, 32'h0000_0000, res(ST_DONE, 0, 0)));
		add_row(typed_row(ACT_INSERT, 32'h0000_0000, 32'h8000_0000, res(ST_DONE, 0, 1)));
		add_row(typed_row(ACT_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, res(ST_DONE, 0, 2)));
		add_row(typed_row(ACT_INSERT, 32'hFFFF_FFFF, 32'h0000_0000,
			res(ST_TOO_CLOSE, 1, 2)));
		add_row(gap_row(31'h0001_0000));
		add_row(typed_row(ACT_INSERT, 32'h0001_0000, 32'h0000_0000,
			res(ST_TOO_CLOSE, 2, 2)));
		add_row(typed_row(ACT_INSERT, 32'h0001_0001, 32'hFFFF_0000, res(ST_DONE, 2, 3)));
		add_row(open_row(ACT_INSERT, 32'h0000_8000, 32'h0F0F_0F0F));
		add_row(open_row(ACT_INSERT, 32'hFFFE_FFFF, 32'hF0F0_F0F0));
		add_row(typed_row(ACT_CLEAR, 32'h5A5A_5A5A, 32'hA5A5_A5A5, res(ST_DONE, 0, 0)));
		add_row(gap_row(31'h0));

		// Gap settings for the random phases: extremes, one Q16.16 unit, a
		// random wide one and tight ones that let the table fill up.
		gap_plan[0] = 31'h0;
		gap_plan[1] = 31'h7FFF_FFFF;
		gap_plan[2] = 31'h1;
		gap_plan[3] = 31'h0001_0000;
		gap_plan[4] = GAP_W'($urandom);
		gap_plan[5] = 31'h0000_0FFF;
		gap_plan[6] = GAP_W'($urandom_range(0, 'h3FFF));
		gap_plan[7] = 31'h0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_GAP) begin
				stop_offer();
				drain();
				set_gap(plan[i].gap);
			end else begin
				offer(plan[i].beat, plan[i].typed, plan[i].want);
			end
		end

		// Random phases: mostly inserts so the table climbs to full and the
		// full and too-close paths get exercised; clears are rare except in
		// two phases that keep the table shallow.
		for (int p = 0; p < PHASES; p++) begin
			stop_offer();
			drain();
			set_gap(gap_plan[p]);
			clear_odds = (p == 2 || p == 5) ? 30 : 250;
			repeat (PHASE_LEN) begin
				beat.action    = ($urandom_range(0, clear_odds - 1) == 0) ? ACT_CLEAR : ACT_INSERT;
				beat.new_key   = pick_key();
				beat.new_value = $urandom;
				offer(beat, 1'b0, '0);
			end
		end

		stop_offer();
		drain();
		repeat (20) @(posedge clk);

		$display("run: %0d request beats, %0d placed, %0d too close, %0d table full, %0d clears",
			n_beats, n_placed, n_close, n_full, n_clear);
		$display("run: %0d min_key_gap writes with readback, two long response holds",
			n_gap_set);
		if (n_bad == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", n_bad);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
